### src/gsa_pkg.sv
package gsa_pkg;

  localparam int GEN_W      = 32;
  localparam int SIDX_W     = 16;
  localparam int HANDLE_W   = 64;
  localparam int LIVE_W     = 17;
  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 104;
  localparam int OUT_USER_W = 1;

  localparam logic [GEN_W-1:0] GEN_MAX   = 32'hffff_ffff;
  localparam logic [GEN_W-1:0] GEN_FIRST = 32'd1;

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_RELEASE  = 2'd1,
    OP_LOOKUP   = 2'd2,
    OP_VALIDATE = 2'd3
  } op_t;

  typedef struct packed {
    logic             active;
    logic [GEN_W-1:0] gen;
  } entry_t;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic scan_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_more;
  } status_t;

endpackage

### src/gsa_ctrl.sv
module gsa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  gsa_pkg::status_t status,
  output gsa_pkg::cmd_t    cmd
);
  import gsa_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL
  } state_t;

  state_t state;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd.clear_step = (state == S_CLEAR);
    cmd.accept     = (state == S_IDLE) && s_tvalid;
    cmd.scan_step  = (state == S_EVAL) && status.scan_more;
    cmd.commit     = (state == S_EVAL) && !status.scan_more && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (status.clear_done) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (cmd.commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

### src/gsa_datapath.sv
module gsa_datapath #(
  parameter int CAPACITY = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  gsa_pkg::cmd_t                cmd,
  output gsa_pkg::status_t             status,
  input  logic [1:0]                   in_op,
  input  logic [gsa_pkg::SIDX_W-1:0]   in_sidx,
  input  logic [gsa_pkg::HANDLE_W-1:0] in_handle,
  output logic                         out_ok,
  output logic [gsa_pkg::SIDX_W-1:0]   out_index,
  output logic [gsa_pkg::HANDLE_W-1:0] out_handle,
  output logic [gsa_pkg::LIVE_W-1:0]   out_live
);
  import gsa_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_C = IDX_W'(CAPACITY - 1);

  entry_t mem [CAPACITY];
  entry_t rdata;

  op_t                 op;
  logic [SIDX_W-1:0]   sidx;
  logic [HANDLE_W-1:0] hnd;
  logic                in_range;
  logic [IDX_W-1:0]    addr;
  logic [CNT_W-1:0]    hint;
  logic [CNT_W-1:0]    count;

  logic                full;
  logic                rng_in;
  logic                live;
  logic                valid_hnd;
  logic                re;
  logic                we;
  logic [IDX_W-1:0]    raddr;
  entry_t              wdata;
  logic [GEN_W-1:0]    gen_inc;
  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    hint_next;

  assign full      = (count == CAP_C);
  assign live      = in_range && rdata.active;
  assign valid_hnd = live && (rdata.gen == hnd[HANDLE_W-1:GEN_W]);
  assign gen_inc   = (rdata.gen == GEN_MAX) ? GEN_FIRST : rdata.gen + 1'b1;

  assign status.clear_done = (addr == LAST_C);
  assign status.scan_more  = (op == OP_ALLOC) && !full && rdata.active;

  always_comb begin
    if (op_t'(in_op) == OP_VALIDATE) begin
      rng_in = (in_handle[GEN_W-1:0] < 32'(CAPACITY));
    end else begin
      rng_in = ({1'b0, in_sidx} < 17'(CAPACITY));
    end
    re    = 1'b0;
    raddr = addr + 1'b1;
    if (cmd.accept) begin
      case (op_t'(in_op))
        OP_ALLOC: begin
          re    = !full;
          raddr = hint[IDX_W-1:0];
        end
        OP_VALIDATE: begin
          re    = rng_in;
          raddr = in_handle[IDX_W-1:0];
        end
        default: begin
          re    = rng_in;
          raddr = in_sidx[IDX_W-1:0];
        end
      endcase
    end else if (cmd.scan_step) begin
      re = 1'b1;
    end
  end

  always_comb begin
    we         = cmd.clear_step;
    wdata      = '{active: 1'b0, gen: GEN_FIRST};
    count_next = count;
    hint_next  = hint;
    if (cmd.commit) begin
      case (op)
        OP_ALLOC: begin
          if (!full) begin
            we         = 1'b1;
            wdata      = '{active: 1'b1, gen: rdata.gen};
            count_next = count + 1'b1;
            hint_next  = CNT_W'(addr) + 1'b1;
          end
        end
        OP_RELEASE: begin
          if (live) begin
            we         = 1'b1;
            wdata      = '{active: 1'b0, gen: gen_inc};
            count_next = count - 1'b1;
            if (CNT_W'(addr) < hint) begin
              hint_next = CNT_W'(addr);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr  <= '0;
      hint  <= '0;
      count <= '0;
    end else begin
      if (cmd.clear_step || cmd.scan_step) begin
        addr <= addr + 1'b1;
      end else if (cmd.accept) begin
        addr <= raddr;
      end
      hint  <= hint_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op       <= op_t'(in_op);
      sidx     <= in_sidx;
      hnd      <= in_handle;
      in_range <= rng_in;
    end
    if (cmd.commit) begin
      out_live   <= LIVE_W'(count_next);
      out_ok     <= 1'b0;
      out_index  <= '0;
      out_handle <= '0;
      case (op)
        OP_ALLOC: begin
          out_ok    <= !full;
          out_index <= full ? '0 : SIDX_W'(addr);
        end
        OP_RELEASE: begin
          out_ok <= live;
        end
        OP_LOOKUP: begin
          out_ok     <= live;
          out_handle <= live ? {rdata.gen, 16'd0, sidx} : '0;
        end
        default: begin
          out_ok    <= valid_hnd;
          out_index <= valid_hnd ? hnd[SIDX_W-1:0] : '0;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CAP_C)
    else $error("live count above capacity");
  a_hint_bound: assert property (@(posedge clk) disable iff (rst) !full |-> hint < CAP_C)
    else $error("search hint beyond last slot while a slot is free");
  a_scan_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> !full)
    else $error("free slot search with no free slot");
  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && op == OP_ALLOC && !full |=> count == $past(count) + 1'b1)
    else $error("allocation did not count the slot");
`endif

endmodule

### src/generational_slot_allocator.sv
// generational slot allocator
// input word: tuser carries the operation (allocate, release, handle of
// index, validate handle), tdata the slot index and the handle to check.
// output word: tuser carries ok, tdata the allocated or validated index,
// the looked-up handle and the live slot count after the operation.
// a handle is the slot generation in bits 63..32 and the index below it.
// one result word for every input word, in order.
// release, lookup and validate read the slot's generation entry into a
// register, then commit the result; release also writes the entry back.
// allocate searches upward from the lowest slot that may be free, one
// memory entry a cycle, passing over active slots; the lowest free slot
// is usually found at once.
// the input is not ready while an operation is in progress, also in the
// cycle that finishes it, so the next word waits for the last to finish.
// one word is in progress at a time; the next is taken while a result
// waits in the output register, and is held back if the receiver stalls.
// after reset the generation memory is swept, every slot set to
// generation one, free; no input word is accepted during the sweep.
module generational_slot_allocator #(
  parameter int CAPACITY = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // slot_index, handle_in
  input  logic [gsa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // operation
  input  logic [gsa_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // slot_out, handle_out, live_count, zero fill
  output logic [gsa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // ok
  output logic [gsa_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
  import gsa_pkg::*;

  cmd_t                cmd;
  status_t             status;
  logic                out_ok;
  logic [SIDX_W-1:0]   out_index;
  logic [HANDLE_W-1:0] out_handle;
  logic [LIVE_W-1:0]   out_live;

  gsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gsa_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_op      (s_axis_tuser),
    .in_sidx    (s_axis_tdata[SIDX_W-1:0]),
    .in_handle  (s_axis_tdata[SIDX_W+HANDLE_W-1:SIDX_W]),
    .out_ok     (out_ok),
    .out_index  (out_index),
    .out_handle (out_handle),
    .out_live   (out_live)
  );

  assign m_axis_tdata = {7'd0, out_live, out_handle, out_index};
  assign m_axis_tuser = out_ok;

endmodule
